[hw/rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is held.
`define PCLW_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pclw check failed: same-cycle implication");

// Next-cycle implication, quiet while reset is held.
`define PCLW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pclw check failed: next-cycle implication");

`endif

[hw/rtl/pclw_pkg.sv]
`default_nettype none

package pclw_pkg;

  localparam int OFF_W = 12;
  localparam int CNT_W = 8;

  // Visited map geometry; one entry per dword of config space
  localparam int VISITED_ENTRIES = 1024;
  localparam int VIS_AW          = $clog2(VISITED_ENTRIES);
  localparam int EPOCH_W         = 8;

  localparam logic [CNT_W-1:0] CONV_MAX_NODES = 8'd48;
  localparam logic [CNT_W-1:0] EXT_MAX_NODES  = 8'd128;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_HEADER = 1'b1;
  localparam logic MODE_CONV  = 1'b0;
  localparam logic MODE_EXT   = 1'b1;

  localparam int               STATUS_LIST_BIT = 4;
  localparam logic [OFF_W-1:0] CONV_MIN        = 12'h040;
  localparam logic [7:0]       CONV_MASK       = 8'hFC;
  localparam logic [OFF_W-1:0] EXT_START       = 12'h100;
  localparam logic [OFF_W-1:0] EXT_END         = 12'hFFC;
  localparam logic [15:0]      REBAR_ID        = 16'h0015;
  localparam logic [31:0]      HDR_ALL_ONES    = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        cmd;
    logic [15:0] status_word;
    logic [7:0]  cap_pointer;
    logic [31:0] header_word;
  } pclw_in_t;

  typedef struct packed {
    logic [OFF_W-1:0] read_offset;
    logic             node_valid;
    logic [15:0]      cap_id;
    logic [3:0]       cap_version;
    logic [OFF_W-1:0] cap_offset;
    logic             walk_done;
    logic             walk_valid;
    logic [CNT_W-1:0] node_count;
    logic             rebar_present;
  } pclw_out_t;

  typedef struct packed {
    logic             rd_en;
    logic [OFF_W-1:0] rd_off;
    logic             wr_en;
    logic [OFF_W-1:0] wr_off;
    logic             new_walk;
    logic             clear_req;
  } pclw_map_req_t;

  typedef struct packed {
    logic seen;
    logic busy;
    logic epoch_full;
  } pclw_map_rsp_t;

  function automatic logic [VIS_AW-1:0] vis_idx(input logic [OFF_W-1:0] off);
    return off[VIS_AW+1:2];
  endfunction

  function automatic logic in_map(input logic [OFF_W-1:0] off);
    return int'(off[OFF_W-1:2]) < VISITED_ENTRIES;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/pclw_visit_map.sv]
`default_nettype none

// Visited map: epoch tag per dword. An entry counts as visited when its tag
// equals the live epoch. Epoch wrap and reset need a full sweep to zero.
module pclw_visit_map (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pclw_pkg::pclw_map_req_t req,
  output pclw_pkg::pclw_map_rsp_t rsp
);
  import pclw_pkg::*;

  logic [EPOCH_W-1:0] mem [VISITED_ENTRIES];

  logic [EPOCH_W-1:0] rd_q_r;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic               byp_r;
  logic               in_map_r;
  logic               clearing_r;
  logic [VIS_AW-1:0]  clr_idx_r;

  logic               we;
  logic [VIS_AW-1:0]  wa;
  logic [EPOCH_W-1:0] wd;
  logic [VIS_AW-1:0]  rd_idx;
  logic [VIS_AW-1:0]  wr_idx;
  logic               wr_live;

  assign rd_idx    = vis_idx(req.rd_off);
  assign wr_idx    = vis_idx(req.wr_off);
  assign wr_live   = req.wr_en && in_map(req.wr_off);
  assign epoch_nxt = req.new_walk ? epoch_r + EPOCH_W'(1) : epoch_r;

  always_comb begin
    if (clearing_r) begin
      we = 1'b1;
      wa = clr_idx_r;
      wd = '0;
    end else begin
      we = wr_live;
      wa = wr_idx;
      wd = epoch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (req.rd_en) begin
      rd_q_r   <= mem[rd_idx];
      // same-edge write to the read entry is not in rd_q_r yet
      byp_r    <= wr_live && (wr_idx == rd_idx);
      in_map_r <= in_map(req.rd_off);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
      epoch_r    <= '0;
    end else if (clearing_r) begin
      clr_idx_r <= clr_idx_r + VIS_AW'(1);
      if (clr_idx_r == VIS_AW'(VISITED_ENTRIES - 1)) begin
        clearing_r <= 1'b0;
        epoch_r    <= '0;
      end
    end else if (req.clear_req) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      epoch_r <= epoch_nxt;
    end
  end

  assign rsp.seen       = !in_map_r || byp_r || (rd_q_r == epoch_r);
  assign rsp.busy       = clearing_r;
  // a start leaving the input register may be taking the last tag
  assign rsp.epoch_full = (epoch_r == '1) || (epoch_nxt == '1);

endmodule

`default_nettype wire

[hw/rtl/pci_capability_list_walker.sv]
// PCI capability list walker.
// Input channel (in_valid/in_ready/in_data): a start transaction (cmd 0)
// opens a walk; each header transaction (cmd 1) carries the header found at
// the offset named by the previous result. Result channel (out_valid/
// out_ready/out_data): exactly one result per input transaction, in order.
// Config channel (cfg_valid/cfg_ready/cfg_data) sets walk_mode; it is always
// ready and must only be written while the walker is idle.
// Result path: the input register, then the result register, which drives
// out_valid. Throughput: one transaction per cycle while the result is taken
// and the visited map is not sweeping, set by the single evaluate stage and
// the one-read visited map.
// Reset: a sweep zeroes all VISITED_ENTRIES (1024) visited map entries;
// in_ready stays low meanwhile. The map uses an 8-bit walk epoch, so every
// 256th start waits for another full sweep of the map before it is taken.
// Receiver stall: the result register holds; one more transaction sits in
// the input register, after which in_ready drops until out_ready returns.
`default_nettype none

module pci_capability_list_walker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pclw_pkg::pclw_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pclw_pkg::pclw_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import pclw_pkg::*;

  // configuration
  logic mode_r;

  // input register
  logic     s1_valid_r;
  pclw_in_t s1_item_r;

  // walk state
  logic [OFF_W-1:0] cur_off_r, cur_off_nxt;
  logic [CNT_W-1:0] nodes_r,   nodes_nxt;
  logic             active_r,  active_nxt;
  logic             ok_r,      ok_nxt;
  logic             rebar_r,   rebar_nxt;

  // result register
  logic      out_valid_r;
  pclw_out_t out_data_r;

  pclw_map_req_t map_req;
  pclw_map_rsp_t map_rsp;

  logic             adv;
  logic             in_take;
  logic             clr_block;
  logic [OFF_W-1:0] in_next_off;

  // evaluate stage
  logic             mark;
  logic [OFF_W-1:0] mark_off;
  logic             node;
  logic [15:0]      id;
  logic [3:0]       ver;
  logic [OFF_W-1:0] noff;
  logic [CNT_W-1:0] cnt_inc;
  logic [OFF_W-1:0] conv_ptr;
  logic [OFF_W-1:0] conv_next;
  logic [OFF_W-1:0] ext_next;
  logic [31:0]      hdr;

  // ---------------------------------------------------------------
  // Handshake. The result register frees when taken, so the input
  // register moves on in the same cycle.
  // ---------------------------------------------------------------
  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  // a start that needs a fresh epoch waits for the map sweep
  assign clr_block = (in_data.cmd == CMD_START) && map_rsp.epoch_full;
  assign in_ready  = (!s1_valid_r || adv) && !map_rsp.busy && !clr_block;
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Map read looks up the link carried by the arriving header, so the
  // visited bit is registered alongside the transaction.
  assign in_next_off = (mode_r == MODE_EXT) ? in_data.header_word[31:20]
                                            : {4'b0, in_data.header_word[15:8] & CONV_MASK};

  always_comb begin
    map_req.rd_en     = in_take;
    map_req.rd_off    = in_next_off;
    map_req.wr_en     = adv && mark;
    map_req.wr_off    = mark_off;
    map_req.new_walk  = adv && (s1_item_r.cmd == CMD_START);
    // only sweep once no transaction in flight can still mark the map
    map_req.clear_req = in_valid && clr_block && !s1_valid_r && !map_rsp.busy;
  end

  pclw_visit_map u_visit_map (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (map_req),
    .rsp   (map_rsp)
  );

  // ---------------------------------------------------------------
  // Evaluate one transaction from the input register.
  // ---------------------------------------------------------------
  assign hdr       = s1_item_r.header_word;
  assign cnt_inc   = nodes_r + CNT_W'(1);
  assign conv_ptr  = {4'b0, s1_item_r.cap_pointer & CONV_MASK};
  assign conv_next = {4'b0, hdr[15:8] & CONV_MASK};
  assign ext_next  = hdr[31:20];

  always_comb begin
    cur_off_nxt = cur_off_r;
    nodes_nxt   = nodes_r;
    active_nxt  = active_r;
    ok_nxt      = ok_r;
    rebar_nxt   = rebar_r;
    mark        = 1'b0;
    mark_off    = cur_off_r;
    node        = 1'b0;
    id          = '0;
    ver         = '0;
    noff        = '0;

    if (s1_item_r.cmd == CMD_START) begin
      nodes_nxt = '0;
      ok_nxt    = 1'b1;
      rebar_nxt = 1'b0;
      if (mode_r == MODE_CONV) begin
        if (!s1_item_r.status_word[STATUS_LIST_BIT] || (conv_ptr < CONV_MIN)) begin
          // no list: finished, clean
          active_nxt  = 1'b0;
          cur_off_nxt = '0;
        end else begin
          active_nxt  = 1'b1;
          cur_off_nxt = conv_ptr;
          mark        = 1'b1;
          mark_off    = conv_ptr;
        end
      end else begin
        active_nxt  = 1'b1;
        cur_off_nxt = EXT_START;
        mark        = 1'b1;
        mark_off    = EXT_START;
      end
    end else if (active_r) begin
      if (mode_r == MODE_CONV) begin
        node      = 1'b1;
        id        = {8'b0, hdr[7:0]};
        noff      = cur_off_r;
        nodes_nxt = cnt_inc;
        if (cnt_inc >= CONV_MAX_NODES) begin
          ok_nxt      = 1'b0;
          active_nxt  = 1'b0;
          cur_off_nxt = '0;
        end else if (conv_next == '0) begin
          active_nxt  = 1'b0;
          cur_off_nxt = '0;
        end else if ((conv_next == cur_off_r) || (conv_next < CONV_MIN) || map_rsp.seen) begin
          ok_nxt      = 1'b0;
          active_nxt  = 1'b0;
          cur_off_nxt = '0;
        end else begin
          mark        = 1'b1;
          mark_off    = conv_next;
          cur_off_nxt = conv_next;
        end
      end else if ((hdr == '0) || (hdr == HDR_ALL_ONES)) begin
        // end-of-list header: no node, clean finish
        active_nxt  = 1'b0;
        cur_off_nxt = '0;
      end else begin
        node      = 1'b1;
        id        = hdr[15:0];
        ver       = hdr[19:16];
        noff      = cur_off_r;
        nodes_nxt = cnt_inc;
        if (hdr[15:0] == REBAR_ID) begin
          rebar_nxt = 1'b1;
        end
        if (cnt_inc >= EXT_MAX_NODES) begin
          ok_nxt      = 1'b0;
          active_nxt  = 1'b0;
          cur_off_nxt = '0;
        end else if (ext_next == '0) begin
          active_nxt  = 1'b0;
          cur_off_nxt = '0;
        end else if ((ext_next == cur_off_r) || (ext_next < EXT_START) ||
                     (ext_next > EXT_END) || (ext_next[1:0] != 2'b00) || map_rsp.seen) begin
          ok_nxt      = 1'b0;
          active_nxt  = 1'b0;
          cur_off_nxt = '0;
        end else begin
          mark        = 1'b1;
          mark_off    = ext_next;
          cur_off_nxt = ext_next;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_CONV;
      s1_valid_r  <= 1'b0;
      cur_off_r   <= '0;
      nodes_r     <= '0;
      active_r    <= 1'b0;
      ok_r        <= 1'b1;
      rebar_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        cur_off_r   <= cur_off_nxt;
        nodes_r     <= nodes_nxt;
        active_r    <= active_nxt;
        ok_r        <= ok_nxt;
        rebar_r     <= rebar_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
    if (adv) begin
      out_data_r.read_offset   <= active_nxt ? cur_off_nxt : '0;
      out_data_r.node_valid    <= node;
      out_data_r.cap_id        <= id;
      out_data_r.cap_version   <= ver;
      out_data_r.cap_offset    <= noff;
      out_data_r.walk_done     <= !active_nxt;
      out_data_r.walk_valid    <= ok_nxt;
      out_data_r.node_count    <= nodes_nxt;
      out_data_r.rebar_present <= rebar_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[hw/rtl/pclw_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module pclw_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input pclw_pkg::pclw_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input pclw_pkg::pclw_out_t out_data,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic                cfg_data
);
  import pclw_pkg::*;

  // stalled result stays offered
  `PCLW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // a finished walk asks for no further header
  `PCLW_ASSERT_IMPLY(a_done_no_read, clk, rst_n, out_valid && out_data.walk_done, out_data.read_offset == '0)

  // a walk still running has not been flagged bad
  `PCLW_ASSERT_IMPLY(a_live_is_ok, clk, rst_n, out_valid && !out_data.walk_done, out_data.walk_valid)

  // requested offsets are dword aligned and never inside the header area
  `PCLW_ASSERT_IMPLY(a_read_aligned, clk, rst_n, out_valid && (out_data.read_offset != '0), (out_data.read_offset[1:0] == 2'b00) && (out_data.read_offset >= CONV_MIN))

endmodule

bind pci_capability_list_walker pclw_checker u_pclw_checker (.*);

`default_nettype wire
